/* rtl/core/mexp_pkg.sv */
// ============================================================================
// Modular exponentiation package
// Shared widths, register map and sequencer codes for the exponentiation core.
// ============================================================================
package mexp_pkg;

    // Width of base, exponent, modulus and result.
    localparam int OPERAND_BITS = 31;

    // Bit counter of the serial multiplier.
    localparam int CNT_W = $clog2(OPERAND_BITS);

    // Stream data width: operand rounded up to whole bytes.
    localparam int TDATA_W = ((OPERAND_BITS + 7) / 8) * 8;

    // Register port: 32-bit words, or 64-bit words for wide operands.
    localparam int APB_DATA_W = (OPERAND_BITS > 32) ? 64 : 32;
    localparam int REG_SHIFT  = (OPERAND_BITS > 32) ? 3 : 2;
    localparam int APB_ADDR_W = REG_SHIFT + 1;

    // Register indexes.
    localparam logic REG_EXPONENT = 1'b0;
    localparam logic REG_MODULUS  = 1'b1;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DONE
    } state_t;

    // Which modular product the multiplier is working on.
    typedef enum logic [1:0] {
        OP_ONE,   // 1 * 1 mod m: initial result
        OP_BASE,  // 1 * base mod m: reduced base
        OP_RES,   // result * square
        OP_SQ     // square * square
    } op_t;

endpackage

/* rtl/core/mexp_mulmod.sv */
// ============================================================================
// Bit-serial modular multiplier
// Computes a * b mod m one bit of b per cycle, most significant bit first.
// ============================================================================
module mexp_mulmod (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [mexp_pkg::OPERAND_BITS-1:0] a,
    input  logic [mexp_pkg::OPERAND_BITS-1:0] b,
    input  logic [mexp_pkg::OPERAND_BITS-1:0] m,
    output logic                            done,
    output logic [mexp_pkg::OPERAND_BITS-1:0] product
);
    import mexp_pkg::*;

    localparam int SUM_W = OPERAND_BITS + 2;

    logic [OPERAND_BITS-1:0] acc_reg, acc_next;
    logic [OPERAND_BITS-1:0] a_reg;
    logic [OPERAND_BITS-1:0] b_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;

    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] m_one;
    logic [SUM_W-1:0] m_two;

    // One step: double the accumulator, add a on a set bit, then bring the
    // sum (below 3m) back under m with a single selected subtraction.
    always_comb begin
        m_one = SUM_W'(m);
        m_two = SUM_W'(m) << 1;
        sum   = (SUM_W'(acc_reg) << 1)
              + (b_reg[OPERAND_BITS-1] ? SUM_W'(a_reg) : '0);
        if (sum >= m_two) begin
            acc_next = OPERAND_BITS'(sum - m_two);
        end else if (sum >= m_one) begin
            acc_next = OPERAND_BITS'(sum - m_one);
        end else begin
            acc_next = OPERAND_BITS'(sum);
        end
    end

    // Control: run for one cycle per multiplier bit.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(OPERAND_BITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: operands are captured at start, b shifts out MSB first.
    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= '0;
            a_reg   <= a;
            b_reg   <= b;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            b_reg   <= b_reg << 1;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

/* rtl/core/modular_exponentiation.sv */
// ============================================================================
// Modular exponentiation core
// Raises each incoming base to the configured exponent modulo the modulus.
// ============================================================================
//
// Usage:
//   The exponent and modulus are written over the register port (exponent at
//   offset 0, modulus at offset 4) while the core is idle. Each word on the
//   s_ channel carries a base; one word leaves on the m_ channel holding
//   base^exponent mod modulus in m_tdata and the bad-modulus flag in m_tuser.
//   The power is computed by right-to-left square-and-multiply with a single
//   bit-serial modular multiplier. An item costs 2 + k + p products, where k
//   is the position of the highest set exponent bit plus one and p the number
//   of set exponent bits. A zero modulus gives a flagged zero result.
//   One item is processed at a time; s_tready is high while the core is idle.
//   The result sits in an output register, so the next base is accepted while
//   a finished result waits; if the receiver stalls, the following result
//   holds in the sequencer until the output register frees up.
//   Reset clears the channels and sets exponent 0 and modulus 1.
//
module modular_exponentiation (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mexp_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [mexp_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mexp_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    // Input words
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [mexp_pkg::TDATA_W-1:0]       s_tdata,   // base
    // Result words
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [mexp_pkg::TDATA_W-1:0]       m_tdata,   // power
    output logic                               m_tuser    // bad_modulus
);
    import mexp_pkg::*;

    logic [OPERAND_BITS-1:0] exponent_reg;
    logic [OPERAND_BITS-1:0] modulus_reg;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic   start_reg, start_next;
    logic   bad_reg, bad_next;

    logic [OPERAND_BITS-1:0] base_reg, base_next;
    logic [OPERAND_BITS-1:0] exp_reg, exp_next;
    logic [OPERAND_BITS-1:0] res_reg, res_next;
    logic [OPERAND_BITS-1:0] sq_reg, sq_next;

    logic                    out_valid_reg, out_valid_next;
    logic [OPERAND_BITS-1:0] out_power_reg, out_power_next;
    logic                    out_bad_reg, out_bad_next;

    logic                    mul_done;
    logic [OPERAND_BITS-1:0] mul_product;
    logic [OPERAND_BITS-1:0] mul_a;
    logic [OPERAND_BITS-1:0] mul_b;

    logic cfg_write;
    logic in_accept;

    // Register port: always ready, index taken from the word address.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exponent_reg <= '0;
            modulus_reg  <= OPERAND_BITS'(1);
        end else if (cfg_write) begin
            unique case (paddr[APB_ADDR_W-1])
                REG_EXPONENT: exponent_reg <= pwdata[OPERAND_BITS-1:0];
                REG_MODULUS:  modulus_reg  <= pwdata[OPERAND_BITS-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[APB_ADDR_W-1])
            REG_EXPONENT: prdata = APB_DATA_W'(exponent_reg);
            REG_MODULUS:  prdata = APB_DATA_W'(modulus_reg);
            default:      prdata = '0;
        endcase
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        case (op_reg)
            OP_ONE: begin
                mul_a = OPERAND_BITS'(1);
                mul_b = OPERAND_BITS'(1);
            end
            OP_BASE: begin
                mul_a = OPERAND_BITS'(1);
                mul_b = base_reg;
            end
            OP_RES: begin
                mul_a = res_reg;
                mul_b = sq_reg;
            end
            default: begin
                mul_a = sq_reg;
                mul_b = sq_reg;
            end
        endcase
    end

    mexp_mulmod u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .a       (mul_a),
        .b       (mul_b),
        .m       (modulus_reg),
        .done    (mul_done),
        .product (mul_product)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    // Sequencer state register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_ONE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working values and output payload.
    always_ff @(posedge aclk) begin
        bad_reg       <= bad_next;
        base_reg      <= base_next;
        exp_reg       <= exp_next;
        res_reg       <= res_next;
        sq_reg        <= sq_next;
        out_power_reg <= out_power_next;
        out_bad_reg   <= out_bad_next;
    end

    // Square-and-multiply sequencing, least significant exponent bit first.
    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        start_next     = 1'b0;
        bad_next       = bad_reg;
        base_next      = base_reg;
        exp_next       = exp_reg;
        res_next       = res_reg;
        sq_next        = sq_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_power_next = out_power_reg;
        out_bad_next   = out_bad_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    base_next = s_tdata[OPERAND_BITS-1:0];
                    exp_next  = exponent_reg;
                    res_next  = '0;
                    if (modulus_reg == '0) begin
                        bad_next   = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        bad_next   = 1'b0;
                        op_next    = OP_ONE;
                        start_next = 1'b1;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                if (mul_done) begin
                    case (op_reg)
                        OP_ONE: begin
                            res_next   = mul_product;
                            op_next    = OP_BASE;
                            start_next = 1'b1;
                        end
                        OP_BASE: begin
                            sq_next = mul_product;
                            if (exp_reg == '0) begin
                                state_next = ST_DONE;
                            end else begin
                                op_next    = exp_reg[0] ? OP_RES : OP_SQ;
                                start_next = 1'b1;
                            end
                        end
                        OP_RES: begin
                            res_next   = mul_product;
                            op_next    = OP_SQ;
                            start_next = 1'b1;
                        end
                        default: begin
                            sq_next  = mul_product;
                            exp_next = exp_reg >> 1;
                            if (exp_reg[OPERAND_BITS-1:1] == '0) begin
                                state_next = ST_DONE;
                            end else begin
                                op_next    = exp_reg[1] ? OP_RES : OP_SQ;
                                start_next = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_DONE: begin
                // Hand the result to the output register once it is free.
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_power_next = bad_reg ? '0 : res_reg;
                    out_bad_next   = bad_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'(out_power_reg);
    assign m_tuser  = out_bad_reg;

endmodule
